@@ hdl/rtp_timestamp_matcher_macros.svh @@
// Assertion helpers shared by the timestamp matcher RTL.
`ifndef RTP_TIMESTAMP_MATCHER_MACROS_SVH
`define RTP_TIMESTAMP_MATCHER_MACROS_SVH

// Checked on every rising edge of clock, held off while reset is high.
`define RTPM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication from a trigger to a condition in the following cycle.
`define RTPM_ASSERT_NEXT(label, trig, cond, msg) \
   `RTPM_ASSERT(label, (trig) |=> (cond), msg)

`endif

@@ hdl/rtpm_pkg.sv @@
package rtpm_pkg;

   localparam int STAMP_W = 32;
   localparam int INDEX_W = 3;
   localparam int ACTIVE_W = 3;
   localparam int TOTAL_W = 32;
   // Wide enough for an active count of up to eight components.
   localparam int COUNT_W = 4;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;

   typedef enum logic [2:0] {
      OUTCOME_ORDER_ERROR = 3'd0,
      OUTCOME_DROPPED     = 3'd1,
      OUTCOME_RESTARTED   = 3'd2,
      OUTCOME_MATCHED     = 3'd3,
      OUTCOME_PENDING     = 3'd4,
      OUTCOME_BAD_INDEX   = 3'd5
   } outcome_type;

   typedef struct packed {
      logic [INDEX_W-1:0] comp_id;
      logic [STAMP_W-1:0] frame_timestamp;
   } req_type;

   typedef struct packed {
      outcome_type        outcome;
      logic [TOTAL_W-1:0] matched_count;
      logic [TOTAL_W-1:0] mismatch_count;
      logic [TOTAL_W-1:0] order_error_count;
   } rsp_type;

   typedef struct packed {
      outcome_type outcome;
      logic        store;
      logic        clear_pending;
      logic        set_pending;
      logic        inc_matched;
      logic        inc_mismatch;
      logic        inc_order;
   } decision_type;

   // Serial-number ordering of wrapping stamps: true when a comes before b.
   function automatic logic stamp_before(logic [STAMP_W-1:0] a, logic [STAMP_W-1:0] b);
      if (a[STAMP_W-1] == b[STAMP_W-1]) begin
         return a < b;
      end
      return a[STAMP_W-2:0] > b[STAMP_W-2:0];
   endfunction

endpackage

@@ hdl/rtpm_match.sv @@
module rtpm_match #(
   parameter int MAX_COMPONENTS = 4
) (
   input  logic [rtpm_pkg::ACTIVE_W-1:0] active,
   input  rtpm_pkg::req_type              item,
   input  logic [MAX_COMPONENTS-1:0]      seen,
   input  logic [MAX_COMPONENTS-1:0]      pending,
   input  logic [rtpm_pkg::STAMP_W-1:0]   last_stamp [MAX_COMPONENTS],
   output rtpm_pkg::decision_type         decision
);

   localparam logic [rtpm_pkg::COUNT_W-1:0] MaxCount = rtpm_pkg::COUNT_W'(MAX_COMPONENTS);

   always_comb begin
      logic [rtpm_pkg::COUNT_W-1:0] count;
      logic [MAX_COMPONENTS-1:0]    hit;
      logic [rtpm_pkg::STAMP_W-1:0] own_last;
      logic                         own_seen;
      logic                         bad;
      logic                         order_err;
      logic                         decided;
      logic                         dropped;
      logic                         all_others;
      logic                         active_k;

      count = (rtpm_pkg::COUNT_W'(active) > MaxCount) ? MaxCount
                                                       : rtpm_pkg::COUNT_W'(active);
      bad = rtpm_pkg::COUNT_W'(item.comp_id) >= count;
      own_last = '0;
      own_seen = 1'b0;
      for (int k = 0; k < MAX_COMPONENTS; k++) begin
         hit[k] = item.comp_id == rtpm_pkg::INDEX_W'(k);
         if (hit[k]) begin
            own_last = last_stamp[k];
            own_seen = seen[k];
         end
      end
      order_err = own_seen && (item.frame_timestamp == own_last ||
                  rtpm_pkg::stamp_before(item.frame_timestamp, own_last));

      // The lowest-numbered pending component that disagrees decides the outcome.
      decided = 1'b0;
      dropped = 1'b0;
      all_others = 1'b1;
      for (int k = 0; k < MAX_COMPONENTS; k++) begin
         active_k = rtpm_pkg::COUNT_W'(k) < count;
         if (!decided && active_k && !hit[k] && pending[k]) begin
            if (rtpm_pkg::stamp_before(item.frame_timestamp, last_stamp[k])) begin
               decided = 1'b1;
               dropped = 1'b1;
            end else if (rtpm_pkg::stamp_before(last_stamp[k], item.frame_timestamp)) begin
               decided = 1'b1;
            end
         end
         if (active_k && !hit[k] && !pending[k]) begin
            all_others = 1'b0;
         end
      end

      decision = '0;
      if (bad) begin
         decision.outcome = rtpm_pkg::OUTCOME_BAD_INDEX;
      end else if (order_err) begin
         decision.outcome = rtpm_pkg::OUTCOME_ORDER_ERROR;
         decision.clear_pending = 1'b1;
         decision.inc_order = 1'b1;
      end else begin
         decision.store = 1'b1;
         if (decided) begin
            decision.clear_pending = 1'b1;
            decision.inc_mismatch = 1'b1;
            decision.set_pending = !dropped;
            decision.outcome = dropped ? rtpm_pkg::OUTCOME_DROPPED
                                       : rtpm_pkg::OUTCOME_RESTARTED;
         end else if (all_others) begin
            decision.clear_pending = 1'b1;
            decision.inc_matched = 1'b1;
            decision.outcome = rtpm_pkg::OUTCOME_MATCHED;
         end else begin
            decision.set_pending = 1'b1;
            decision.outcome = rtpm_pkg::OUTCOME_PENDING;
         end
      end
   end

endmodule

@@ hdl/rtpm_sat_counter.sv @@
module rtpm_sat_counter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         inc,
   output logic [rtpm_pkg::TOTAL_W-1:0] total_next
);

   logic [rtpm_pkg::TOTAL_W-1:0] total_ff;

   // The value after this event, so that the result can report it directly.
   assign total_next = (inc && total_ff != '1) ? total_ff + 1'b1 : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_next;
      end
   end

endmodule

@@ hdl/rtp_timestamp_matcher.sv @@
// RTP timestamp matcher.
// The req channel carries one new-frame event per transfer: a component index
// and a 32-bit wrapping RTP timestamp. The rsp channel returns exactly one
// result per event: an outcome code and the three saturating totals as they
// stand after that event. The csr port writes the active component count; it
// is to be written only while no event is in flight.
// An event is taken into an input register and decided from there by the
// comparison logic against all components in parallel, and the result
// is registered with the state update at the same edge. One event is
// accepted every cycle while the result register is empty or being read.
// The next event sees the updated state because the per-component flags and
// stamps are written at the edge that loads the result register.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps one more event; req_ready falls only while both are
// full and rsp_ready is low.
// Reset clears all flags, the totals and both stage valids, and sets the
// active count to four; it takes effect at once, with no clearing pass.
`include "rtp_timestamp_matcher_macros.svh"

module rtp_timestamp_matcher #(
   parameter int MAX_COMPONENTS = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rtpm_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rtpm_pkg::rsp_type            rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [rtpm_pkg::ACTIVE_W-1:0] csr_write_data
);

   logic                          in_valid_ff;
   rtpm_pkg::req_type             in_ff;
   logic                          out_valid_ff;
   rtpm_pkg::rsp_type             out_ff;
   logic [rtpm_pkg::ACTIVE_W-1:0] active_ff;
   logic [MAX_COMPONENTS-1:0]     seen_ff;
   logic [MAX_COMPONENTS-1:0]     pending_ff;
   logic [MAX_COMPONENTS-1:0]     pending_in;
   logic [rtpm_pkg::STAMP_W-1:0]  last_stamp_ff [MAX_COMPONENTS];
   rtpm_pkg::decision_type        dec;
   logic                          advance;
   logic [rtpm_pkg::TOTAL_W-1:0]  matched_next;
   logic [rtpm_pkg::TOTAL_W-1:0]  mismatch_next;
   logic [rtpm_pkg::TOTAL_W-1:0]  order_next;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   rtpm_match #(
      .MAX_COMPONENTS(MAX_COMPONENTS)
   ) u_match (
      .active    (active_ff),
      .item      (in_ff),
      .seen      (seen_ff),
      .pending   (pending_ff),
      .last_stamp(last_stamp_ff),
      .decision  (dec)
   );

   rtpm_sat_counter u_matched (
      .clock     (clock),
      .reset     (reset),
      .inc       (advance && dec.inc_matched),
      .total_next(matched_next)
   );

   rtpm_sat_counter u_mismatch (
      .clock     (clock),
      .reset     (reset),
      .inc       (advance && dec.inc_mismatch),
      .total_next(mismatch_next)
   );

   rtpm_sat_counter u_order (
      .clock     (clock),
      .reset     (reset),
      .inc       (advance && dec.inc_order),
      .total_next(order_next)
   );

   always_comb begin
      pending_in = dec.clear_pending ? '0 : pending_ff;
      for (int k = 0; k < MAX_COMPONENTS; k++) begin
         if (dec.set_pending && in_ff.comp_id == rtpm_pkg::INDEX_W'(k)) begin
            pending_in[k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         active_ff    <= rtpm_pkg::ACTIVE_RESET;
         seen_ff      <= '0;
         pending_ff   <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            pending_ff   <= pending_in;
            for (int k = 0; k < MAX_COMPONENTS; k++) begin
               if (dec.store && in_ff.comp_id == rtpm_pkg::INDEX_W'(k)) begin
                  seen_ff[k] <= 1'b1;
               end
            end
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            active_ff <= csr_write_data;
         end
      end
   end

   // Stamps are only read once their seen flag is set, so they need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
      if (advance) begin
         out_ff.outcome           <= dec.outcome;
         out_ff.matched_count     <= matched_next;
         out_ff.mismatch_count    <= mismatch_next;
         out_ff.order_error_count <= order_next;
         for (int k = 0; k < MAX_COMPONENTS; k++) begin
            if (dec.store && in_ff.comp_id == rtpm_pkg::INDEX_W'(k)) begin
               last_stamp_ff[k] <= in_ff.frame_timestamp;
            end
         end
      end
   end

   `RTPM_ASSERT(a_pending_implies_seen, (pending_ff & ~seen_ff) == '0,
                "pending flag set on an unseen component")
   `RTPM_ASSERT_NEXT(a_clear_takes_effect,
                     advance && dec.clear_pending && !dec.set_pending,
                     pending_ff == '0, "pending flags survived a clear")
   `RTPM_ASSERT(a_one_total_per_event,
                !advance || $onehot0({dec.inc_matched, dec.inc_mismatch, dec.inc_order}),
                "more than one total advanced by one event")
   `RTPM_ASSERT(a_stall_only_when_full,
                req_ready || (in_valid_ff && out_valid_ff && !rsp_ready),
                "input stalled while the pipeline could move")

endmodule

@@ verif/rtp_timestamp_matcher_tb.sv @@
module rtp_timestamp_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COMPONENTS = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int SEGMENT_ITEMS = 85;
   localparam int SEGMENT_COUNT = 12;
   localparam logic [rtpm_pkg::STAMP_W-1:0] HALF_RANGE = 32'h8000_0000;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rtpm_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rtpm_pkg::rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [rtpm_pkg::ACTIVE_W-1:0] csr_write_data = '0;

   // Local copy of the matcher state.
   logic [rtpm_pkg::ACTIVE_W-1:0] active_setting;
   logic seen[MAX_COMPONENTS];
   logic waiting[MAX_COMPONENTS];
   logic [rtpm_pkg::STAMP_W-1:0] last_seen_stamp[MAX_COMPONENTS];
   logic [rtpm_pkg::TOTAL_W-1:0] matched_total;
   logic [rtpm_pkg::TOTAL_W-1:0] mismatch_total;
   logic [rtpm_pkg::TOTAL_W-1:0] order_error_total;

   rtpm_pkg::rsp_type due_results[$];
   int failures = 0;
   int cycle_count = 0;
   int req_idle_pct = 18;
   int rsp_idle_pct = 64;
   logic [rtpm_pkg::STAMP_W-1:0] frame_base;

   rtp_timestamp_matcher #(
      .MAX_COMPONENTS(MAX_COMPONENTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // A stamp is earlier when the forward distance to the other one lies in the lower half
   // of the range; exactly half the range apart counts as neither earlier nor later.
   function automatic logic is_earlier(logic [rtpm_pkg::STAMP_W-1:0] a,
                                       logic [rtpm_pkg::STAMP_W-1:0] b);
      logic [rtpm_pkg::STAMP_W-1:0] gap;
      gap = b - a;
      return (gap != '0) && (gap < HALF_RANGE);
   endfunction

   function automatic logic [rtpm_pkg::TOTAL_W-1:0] bump(logic [rtpm_pkg::TOTAL_W-1:0] total);
      return (total == '1) ? total : total + 1'b1;
   endfunction

   function automatic void drop_waiting();
      int k;
      for (k = 0; k < MAX_COMPONENTS; k++) begin
         waiting[k] = 1'b0;
      end
   endfunction

   function automatic int live_components();
      return (active_setting > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(active_setting);
   endfunction

   function automatic void clear_matcher();
      int k;
      active_setting = rtpm_pkg::ACTIVE_RESET;
      for (k = 0; k < MAX_COMPONENTS; k++) begin
         seen[k] = 1'b0;
         waiting[k] = 1'b0;
         last_seen_stamp[k] = '0;
      end
      matched_total = '0;
      mismatch_total = '0;
      order_error_total = '0;
   endfunction

   // Works out the outcome of one frame event and updates the local state.
   function automatic rtpm_pkg::rsp_type match_event(logic [rtpm_pkg::INDEX_W-1:0] idx,
                                                     logic [rtpm_pkg::STAMP_W-1:0] stamp);
      rtpm_pkg::rsp_type r;
      int live;
      int agree;
      int k;
      logic settled;
      live = live_components();
      agree = 0;
      settled = 1'b0;
      r.outcome = rtpm_pkg::OUTCOME_BAD_INDEX;
      if (int'(idx) < live) begin
         if (seen[idx] && (stamp == last_seen_stamp[idx] ||
                           is_earlier(stamp, last_seen_stamp[idx]))) begin
            order_error_total = bump(order_error_total);
            drop_waiting();
            r.outcome = rtpm_pkg::OUTCOME_ORDER_ERROR;
         end else begin
            seen[idx] = 1'b1;
            last_seen_stamp[idx] = stamp;
            // Lowest index decides first.
            for (k = 0; k < live; k++) begin
               if (!settled && k != int'(idx) && waiting[k]) begin
                  if (is_earlier(stamp, last_seen_stamp[k])) begin
                     mismatch_total = bump(mismatch_total);
                     drop_waiting();
                     r.outcome = rtpm_pkg::OUTCOME_DROPPED;
                     settled = 1'b1;
                  end else if (is_earlier(last_seen_stamp[k], stamp)) begin
                     mismatch_total = bump(mismatch_total);
                     drop_waiting();
                     waiting[idx] = 1'b1;
                     r.outcome = rtpm_pkg::OUTCOME_RESTARTED;
                     settled = 1'b1;
                  end else begin
                     agree++;
                  end
               end
            end
            if (!settled) begin
               if (agree == live - 1) begin
                  matched_total = bump(matched_total);
                  drop_waiting();
                  r.outcome = rtpm_pkg::OUTCOME_MATCHED;
               end else begin
                  waiting[idx] = 1'b1;
                  r.outcome = rtpm_pkg::OUTCOME_PENDING;
               end
            end
         end
      end
      r.matched_count = matched_total;
      r.mismatch_count = mismatch_total;
      r.order_error_count = order_error_total;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rtpm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $error("result transfer with no event outstanding: %0h", rsp_payload);
            failures++;
         end else begin
            want = due_results.pop_front();
            check_field("outcome", 32'(want.outcome), 32'(rsp_payload.outcome));
            check_field("matched_count", want.matched_count, rsp_payload.matched_count);
            check_field("mismatch_count", want.mismatch_count, rsp_payload.mismatch_count);
            check_field("order_error_count", want.order_error_count,
                        rsp_payload.order_error_count);
         end
      end
   end

   // Called on a clock edge; returns on the edge at which the event transfer takes place.
   // The valid stays high so that a following event can go out back to back.
   task automatic send_event(logic [rtpm_pkg::INDEX_W-1:0] idx,
                             logic [rtpm_pkg::STAMP_W-1:0] stamp);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{comp_id: idx, frame_timestamp: stamp};
      do @(posedge clock); while (!req_ready);
      due_results.push_back(match_event(idx, stamp));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active_count(logic [rtpm_pkg::ACTIVE_W-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_setting = value;
   endtask

   // Stamp extremes, wrap-around, half-range pairs and each outcome at the reset count.
   task automatic test_stamp_ordering();
      send_event(3'd0, 32'h0000_0000);
      send_event(3'd1, 32'h0000_0000);
      send_event(3'd2, 32'h0000_0000);
      send_event(3'd3, 32'h0000_0000);
      send_event(3'd0, 32'hffff_ffff);
      send_event(3'd0, 32'h8000_0000);
      send_event(3'd1, 32'h8000_0000);
      send_event(3'd2, 32'h7fff_ffff);
      send_event(3'd3, 32'h4000_0000);
      send_event(3'd0, 32'hc000_0000);
      send_event(3'd1, 32'hc000_0000);
      send_event(3'd2, 32'hd000_0000);
      send_event(3'd3, 32'hd000_0000);
      send_event(3'd4, 32'h5555_5555);
      send_event(3'd7, 32'haaaa_aaaa);
      send_event(3'd0, 32'hffff_fff0);
      send_event(3'd1, 32'hffff_fff0);
      send_event(3'd2, 32'hffff_fff0);
      send_event(3'd3, 32'hffff_fff0);
      send_event(3'd1, 32'h0000_0010);
      // A repeated stamp is an order error and loses the pending match.
      send_event(3'd1, 32'h0000_0010);
   endtask

   task automatic test_active_count_limits();
      write_active_count(3'd0);
      send_event(3'd0, 32'h0000_1000);
      send_event(3'd3, 32'h0000_2000);
      write_active_count(3'd1);
      send_event(3'd0, 32'h0000_3000);
      send_event(3'd0, 32'h0000_2fff);
      send_event(3'd1, 32'h0000_4000);
      write_active_count(3'd7);
      send_event(3'd3, 32'h0000_5000);
      send_event(3'd5, 32'h0000_5000);
      write_active_count(3'd5);
      send_event(3'd4, 32'h0000_6000);
      send_event(3'd2, 32'h0000_5000);
   endtask

   // Mostly whole frames with the live components in shuffled order, plus stray stamps,
   // repeats and out-of-range indexes.
   task automatic run_frames(int item_goal);
      int live;
      int sent;
      int j;
      int swap_at;
      int tmp;
      int pick;
      int order[MAX_COMPONENTS];
      logic [rtpm_pkg::STAMP_W-1:0] stamp;
      live = live_components();
      sent = 0;
      while (sent < item_goal) begin
         if (live == 0) begin
            send_event(3'($urandom_range(7)), $urandom());
            sent++;
         end else begin
            case ($urandom_range(9))
               0: frame_base = $urandom();
               1: frame_base = frame_base + 32'h7fff_fff0 + $urandom_range(31);
               default: frame_base = frame_base + $urandom_range(3600, 1);
            endcase
            for (j = 0; j < live; j++) begin
               order[j] = j;
            end
            for (j = live - 1; j > 0; j--) begin
               swap_at = $urandom_range(j);
               tmp = order[j];
               order[j] = order[swap_at];
               order[swap_at] = tmp;
            end
            for (j = 0; j < live; j++) begin
               pick = $urandom_range(99);
               stamp = frame_base;
               if (pick < 4) begin
                  stamp = frame_base - $urandom_range(2);
               end else if (pick < 8) begin
                  stamp = frame_base + $urandom_range(2, 1);
               end else if (pick < 10) begin
                  stamp = $urandom();
               end else if (pick < 13) begin
                  send_event(3'($urandom_range(7, live)), $urandom());
               end
               send_event(3'(order[j]), stamp);
               sent++;
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      int seg;
      logic [rtpm_pkg::ACTIVE_W-1:0] setting;
      frame_base = $urandom();
      for (seg = 0; seg < SEGMENT_COUNT; seg++) begin
         if (seg == SEGMENT_COUNT / 3) begin
            req_idle_pct = 64;
            rsp_idle_pct = 18;
         end else if (seg == 2 * SEGMENT_COUNT / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         case (seg % 4)
            0: setting = 3'd4;
            1: setting = 3'd1;
            2: setting = 3'($urandom_range(7, 2));
            default: setting = ($urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
         endcase
         write_active_count(setting);
         run_frames(SEGMENT_ITEMS);
      end
   endtask

   initial begin
      clear_matcher();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_stamp_ordering();
      test_active_count_limits();
      test_random_traffic();
      drain_results();
      if (failures == 0 && due_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
